/* hw/rtl/lsap_pkg.sv */
// Shared types and constants of the line sensor array position core.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lsap_pkg;

  localparam int MaxChannels  = 8;
  localparam int BarLenMm     = 580;
  localparam int SensorSpanMm = 27;
  localparam int PartialLevel = 20;
  localparam int FullScale    = 64;
  localparam int LevelShift   = 6;
  localparam int LevelW       = 7;
  localparam int ThreshW      = 7;
  localparam int ThreshReset  = 32;
  localparam int PosW         = 10;
  localparam int PosSumW      = 12;
  localparam int CountW       = 4;
  localparam int SpanProdW    = 11;
  localparam int DivSteps     = LevelW - 1;
  localparam int DivCntW      = 3;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 7;

  localparam logic [CfgIdxW-1:0] CfgFireThreshold = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgWhiteLine     = CfgIdxW'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_CLASS,
    ST_POS,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/lsap_if.sv */
// Valid/ready channel interfaces: sample items in, position items out, config writes.
// Depends on lsap_pkg for the fixed field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lsap_in_if #(
  parameter int SAMPLE_BITS = 10
) ();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [SAMPLE_BITS-1:0] sample_0;
  logic [SAMPLE_BITS-1:0] sample_1;
  logic [SAMPLE_BITS-1:0] sample_2;
  logic [SAMPLE_BITS-1:0] sample_3;
  logic [SAMPLE_BITS-1:0] sample_4;
  logic [SAMPLE_BITS-1:0] sample_5;
  logic [SAMPLE_BITS-1:0] sample_6;
  logic [SAMPLE_BITS-1:0] sample_7;

  modport source (
    output valid, func, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    input  ready
  );
  modport sink (
    input  valid, func, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    output ready
  );
endinterface

interface lsap_out_if ();
  logic                        valid;
  logic                        ready;
  logic [lsap_pkg::PosW-1:0]   position_mm;
  logic [lsap_pkg::CountW-1:0] fired_count;
  logic                        partial_seen;
  logic                        line_lost;

  modport source (
    output valid, position_mm, fired_count, partial_seen, line_lost,
    input  ready
  );
  modport sink (
    input  valid, position_mm, fired_count, partial_seen, line_lost,
    output ready
  );
endinterface

interface lsap_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [lsap_pkg::CfgIdxW-1:0]  index;
  logic [lsap_pkg::CfgDataW-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/lsap_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lsap_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 8,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/line_sensor_array_position_core.sv */
// Line position core: per-sensor calibration RAM, shared bit-serial normalizer, position math.
// Depends on lsap_pkg, lsap_if and lsap_ram.
// Measure item: per sensor a read, a load, a bit-serial divide when the span is nonzero, and a
// classify step, then position and emit; the divider yields one level bit per cycle per sensor.
// Calibrate item: one RAM read-modify-write per sensor, each a read and a load step. No result.
// Reset clears the per-entry valid bits at once; an entry not yet written reads as min all ones
// and max zero. No clearing pass. Result waits in an output register; input opens when idle.
`timescale 1ns / 1ps
`default_nettype none

module line_sensor_array_position_core #(
  parameter int NUM_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 10
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lsap_cfg_if.sink cfg_i,
  lsap_in_if.sink  in_i,
  lsap_out_if.source out_o
);

  localparam int ChW         = $clog2(NUM_CHANNELS);
  localparam int Spacing     = lsap_pkg::BarLenMm / (NUM_CHANNELS - 1);
  localparam int SpacingHalf = Spacing / 2;
  localparam int RemW        = SAMPLE_BITS + 1;
  localparam int RamW        = 2 * SAMPLE_BITS;
  localparam logic [ChW-1:0] LastCh = ChW'(NUM_CHANNELS - 1);
  localparam logic [lsap_pkg::DivCntW-1:0] DivLast = lsap_pkg::DivCntW'(lsap_pkg::DivSteps - 1);

  lsap_pkg::state_e state_q, state_d;

  logic                            in_acc;
  logic [SAMPLE_BITS-1:0]          in_samples [lsap_pkg::MaxChannels];
  logic [SAMPLE_BITS-1:0]          samples_q [NUM_CHANNELS];
  logic                            func_q;
  logic [ChW-1:0]                  ch_q, ch_d;
  logic [NUM_CHANNELS-1:0]         entry_vld_q, entry_vld_d;
  logic [lsap_pkg::ThreshW-1:0]    thr_q;
  logic                            white_q;

  logic                            ram_we;
  logic [RamW-1:0]                 ram_wdata;
  logic [RamW-1:0]                 ram_rdata;

  logic [SAMPLE_BITS-1:0]          smp, lo, hi, vclamp, dnum, dden, cal_min, cal_max;
  logic                            span_ok, q_top;

  logic [SAMPLE_BITS-1:0]          div_rem_q, div_rem_d, div_den_q, div_den_d;
  logic [lsap_pkg::LevelW-1:0]     div_quo_q, div_quo_d;
  logic [lsap_pkg::DivCntW-1:0]    div_cnt_q, div_cnt_d;
  logic [RemW-1:0]                 rem2, rem_sub;
  logic                            rem_ge;
  logic [lsap_pkg::LevelW-1:0]     lvl;

  logic [lsap_pkg::CountW-1:0]     fired_q, fired_d;
  logic [ChW-1:0]                  top_q, top_d, part_idx_q, part_idx_d;
  logic [lsap_pkg::LevelW-1:0]     part_lvl_q, part_lvl_d;
  logic                            partial_q, partial_d;

  logic [lsap_pkg::PosSumW-1:0]    off_tab [NUM_CHANNELS];
  logic [ChW-1:0]                  fired_k;
  logic [lsap_pkg::PosSumW-1:0]    base_pos;
  logic [lsap_pkg::SpanProdW-1:0]  span_prod;
  logic signed [lsap_pkg::PosSumW-1:0] third, delta, pos_sum_q, pos_sum_d;
  logic [lsap_pkg::PosW-1:0]       pos_clamp;
  logic                            lost;

  logic [lsap_pkg::PosW-1:0]       last_pos_q, last_pos_d;
  logic                            out_load;
  logic                            out_valid_q, out_valid_d;
  logic [lsap_pkg::PosW-1:0]       out_pos_q;
  logic [lsap_pkg::CountW-1:0]     out_fired_q;
  logic                            out_partial_q, out_lost_q;

  assign in_samples[0] = SAMPLE_BITS'(in_i.sample_0);
  assign in_samples[1] = SAMPLE_BITS'(in_i.sample_1);
  assign in_samples[2] = SAMPLE_BITS'(in_i.sample_2);
  assign in_samples[3] = SAMPLE_BITS'(in_i.sample_3);
  assign in_samples[4] = SAMPLE_BITS'(in_i.sample_4);
  assign in_samples[5] = SAMPLE_BITS'(in_i.sample_5);
  assign in_samples[6] = SAMPLE_BITS'(in_i.sample_6);
  assign in_samples[7] = SAMPLE_BITS'(in_i.sample_7);

  assign in_i.ready  = (state_q == lsap_pkg::ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= lsap_pkg::ThreshW'(lsap_pkg::ThreshReset);
      white_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lsap_pkg::CfgFireThreshold: thr_q   <= cfg_i.data[lsap_pkg::ThreshW-1:0];
        lsap_pkg::CfgWhiteLine:     white_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Calibration store: {max, min} per sensor
  lsap_ram #(
    .WIDTH (RamW),
    .DEPTH (NUM_CHANNELS)
  ) u_calib_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_q),
    .wdata_i (ram_wdata),
    .raddr_i (ch_q),
    .rdata_o (ram_rdata)
  );

  assign smp     = samples_q[ch_q];
  assign lo      = entry_vld_q[ch_q] ? ram_rdata[SAMPLE_BITS-1:0] : '1;
  assign hi      = entry_vld_q[ch_q] ? ram_rdata[RamW-1:SAMPLE_BITS] : '0;
  assign span_ok = hi > lo;
  assign vclamp  = (smp > hi) ? hi : ((smp < lo) ? lo : smp);
  assign dnum    = vclamp - lo;
  assign dden    = hi - lo;
  assign q_top   = (dnum == dden);
  assign cal_max = (smp > hi) ? smp : hi;
  assign cal_min = (smp < lo) ? smp : lo;
  assign ram_wdata = {cal_max, cal_min};

  assign rem2    = {div_rem_q, 1'b0};
  assign rem_ge  = rem2 >= {1'b0, div_den_q};
  assign rem_sub = rem2 - {1'b0, div_den_q};
  assign lvl     = white_q ? (lsap_pkg::LevelW'(lsap_pkg::FullScale) - div_quo_q) : div_quo_q;

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_off
    localparam int OffMm = ((g * lsap_pkg::BarLenMm) / (NUM_CHANNELS - 1)) / 2;
    assign off_tab[g] = lsap_pkg::PosSumW'(OffMm);
  end

  assign fired_k   = ChW'(fired_q - lsap_pkg::CountW'(1));
  assign base_pos  = lsap_pkg::PosSumW'(Spacing)
                   * {{(lsap_pkg::PosSumW-ChW){1'b0}}, LastCh - top_q}
                   + off_tab[fired_k];
  assign span_prod = lsap_pkg::SpanProdW'(lsap_pkg::SensorSpanMm)
                   * lsap_pkg::SpanProdW'(part_lvl_q);
  assign third     = lsap_pkg::PosSumW'(lsap_pkg::SensorSpanMm)
                   - lsap_pkg::PosSumW'(span_prod >> lsap_pkg::LevelShift);
  assign delta     = lsap_pkg::PosSumW'(SpacingHalf) - third;
  assign pos_clamp = pos_sum_q[lsap_pkg::PosSumW-1] ? '0 :
                     (|pos_sum_q[lsap_pkg::PosSumW-2:lsap_pkg::PosW]) ? '1 :
                     pos_sum_q[lsap_pkg::PosW-1:0];
  assign lost      = (fired_q == '0);

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    entry_vld_d = entry_vld_q;
    div_rem_d   = div_rem_q;
    div_den_d   = div_den_q;
    div_quo_d   = div_quo_q;
    div_cnt_d   = div_cnt_q;
    fired_d     = fired_q;
    top_d       = top_q;
    part_idx_d  = part_idx_q;
    part_lvl_d  = part_lvl_q;
    partial_d   = partial_q;
    pos_sum_d   = pos_sum_q;
    last_pos_d  = last_pos_q;
    ram_we      = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      lsap_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          ch_d       = '0;
          fired_d    = '0;
          top_d      = '0;
          part_idx_d = '0;
          part_lvl_d = '0;
          partial_d  = 1'b0;
          state_d    = lsap_pkg::ST_READ;
        end
      end
      lsap_pkg::ST_READ: begin
        state_d = lsap_pkg::ST_LOAD;
      end
      lsap_pkg::ST_LOAD: begin
        if (!func_q) begin
          ram_we            = 1'b1;
          entry_vld_d[ch_q] = 1'b1;
          if (ch_q == LastCh) begin
            state_d = lsap_pkg::ST_IDLE;
          end else begin
            ch_d    = ch_q + ChW'(1);
            state_d = lsap_pkg::ST_READ;
          end
        end else if (span_ok) begin
          div_rem_d = q_top ? '0 : dnum;
          div_den_d = dden;
          div_quo_d = lsap_pkg::LevelW'(q_top);
          div_cnt_d = '0;
          state_d   = lsap_pkg::ST_DIV;
        end else begin
          div_quo_d = '0;
          state_d   = lsap_pkg::ST_CLASS;
        end
      end
      lsap_pkg::ST_DIV: begin
        div_rem_d = rem_ge ? SAMPLE_BITS'(rem_sub) : SAMPLE_BITS'(rem2);
        div_quo_d = {div_quo_q[lsap_pkg::LevelW-2:0], rem_ge};
        div_cnt_d = div_cnt_q + lsap_pkg::DivCntW'(1);
        if (div_cnt_q == DivLast) begin
          state_d = lsap_pkg::ST_CLASS;
        end
      end
      lsap_pkg::ST_CLASS: begin
        if (lvl > thr_q) begin
          fired_d = fired_q + lsap_pkg::CountW'(1);
          top_d   = ch_q;
        end else if (lvl > lsap_pkg::LevelW'(lsap_pkg::PartialLevel)) begin
          partial_d  = 1'b1;
          part_idx_d = ch_q;
          part_lvl_d = lvl;
        end
        if (ch_q == LastCh) begin
          state_d = lsap_pkg::ST_POS;
        end else begin
          ch_d    = ch_q + ChW'(1);
          state_d = lsap_pkg::ST_READ;
        end
      end
      lsap_pkg::ST_POS: begin
        if (!partial_q) begin
          pos_sum_d = base_pos;
        end else if (top_q > part_idx_q) begin
          pos_sum_d = base_pos + delta;
        end else begin
          pos_sum_d = base_pos - delta;
        end
        state_d = lsap_pkg::ST_EMIT;
      end
      lsap_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          if (!lost) begin
            last_pos_d = pos_clamp;
          end
          state_d = lsap_pkg::ST_IDLE;
        end
      end
      default: state_d = lsap_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsap_pkg::ST_IDLE;
      ch_q        <= '0;
      div_cnt_q   <= '0;
      entry_vld_q <= '0;
      last_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      div_cnt_q   <= div_cnt_d;
      entry_vld_q <= entry_vld_d;
      last_pos_q  <= last_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= in_i.func;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        samples_q[i] <= in_samples[i];
      end
    end
    div_rem_q  <= div_rem_d;
    div_den_q  <= div_den_d;
    div_quo_q  <= div_quo_d;
    fired_q    <= fired_d;
    top_q      <= top_d;
    part_idx_q <= part_idx_d;
    part_lvl_q <= part_lvl_d;
    partial_q  <= partial_d;
    pos_sum_q  <= pos_sum_d;
    if (out_load) begin
      out_pos_q     <= lost ? last_pos_q : pos_clamp;
      out_fired_q   <= fired_q;
      out_partial_q <= partial_q;
      out_lost_q    <= lost;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.position_mm  = out_pos_q;
  assign out_o.fired_count  = out_fired_q;
  assign out_o.partial_seen = out_partial_q;
  assign out_o.line_lost    = out_lost_q;

`ifndef SYNTHESIS
  a_div_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lsap_pkg::ST_DIV |-> div_rem_q < div_den_q)
    else $error("divider remainder not below span");

  a_calib_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lsap_pkg::ST_LOAD && entry_vld_q[ch_q]
      |-> ram_rdata[SAMPLE_BITS-1:0] <= ram_rdata[RamW-1:SAMPLE_BITS])
    else $error("calibrated entry has min above max");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q) |-> $past(state_q) == lsap_pkg::ST_EMIT)
    else $error("result raised outside emit");

  a_lost_repeats_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_lost_q |-> out_pos_q == last_pos_q)
    else $error("lost-line result differs from held position");
`endif

endmodule

`default_nettype wire
